FILE: sv/prr_pkg.sv
package prr_pkg;

  // Field widths of the channels.
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 24;
  localparam int PHASE_W    = 4;
  localparam int TAP_W      = 7;
  localparam int UP_W       = 5;
  localparam int DOWN_W     = 8;
  localparam int TAPS_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Default sizing of the coefficient store and delay line.
  localparam int MAX_TAPS_DEF = 128;
  localparam int MAX_UP_DEF   = 16;

  // Phase residue and per-sample result limit.
  localparam int RESIDUE_W    = 9;
  localparam int RESULT_CAP   = 16;
  localparam int RESULT_CNT_W = $clog2(RESULT_CAP + 1);

  // Multiply-accumulate arithmetic: Q2.22 coefficient times integer sample.
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS = 22;
  localparam int SAT_MAX   = 8388607;
  localparam int SAT_MIN   = -8388608;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_COEF   = 1'b1
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP   = 2'd0,
    REG_DOWN = 2'd1,
    REG_TAPS = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic clr;  // drop the running sum
    logic vld;  // coefficient and sample operands are valid this cycle
  } mac_ctrl_t;

endpackage

FILE: sv/prr_if.sv
interface prr_in_if import prr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [PHASE_W-1:0]         coef_phase;
  logic [TAP_W-1:0]           coef_tap;
  logic signed [COEF_W-1:0]   coef_value;

  modport source (output valid, req_type, sample_in, coef_phase, coef_tap, coef_value,
                  input ready);
  modport sink   (input valid, req_type, sample_in, coef_phase, coef_tap, coef_value,
                  output ready);
endinterface

interface prr_out_if import prr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       last;

  modport source (output valid, sample_out, last, input ready);
  modport sink   (input valid, sample_out, last, output ready);
endinterface

interface prr_cfg_if import prr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/prr_mac.sv
module prr_mac import prr_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctrl_t                  ctrl_i,
  input  logic signed [COEF_W-1:0]   coef_i,
  input  logic signed [SAMPLE_W-1:0] smp_i,
  output logic                       busy_o,
  output logic signed [SAMPLE_W-1:0] result_o
);

  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS + 1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] QMAX = ACC_W'(SAT_MAX);
  localparam logic signed [ACC_W-1:0] QMIN = ACC_W'(SAT_MIN);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  quo;

  // Product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.vld && !ctrl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * smp_i;
  end

  // Accumulate stage.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Round half up, then clip to the sample range.
  always_comb begin
    rnd = acc_q + HALF;
    quo = rnd >>> FRAC_BITS;
    if (quo > QMAX) begin
      result_o = SAMPLE_W'(QMAX);
    end else if (quo < QMIN) begin
      result_o = SAMPLE_W'(QMIN);
    end else begin
      result_o = quo[SAMPLE_W-1:0];
    end
  end

  assign busy_o = prod_vld_q;

endmodule

FILE: sv/polyphase_rational_resampler.sv
// Rational L/M polyphase FIR resampler.
// Channels: req_i takes either a sample (req_type = 0) or a coefficient write
// (req_type = 1) into phase row coef_phase, tap coef_tap. res_o returns the
// resampled outputs; last marks the final output caused by one sample.
// cfg_i writes up_factor (index 0), down_factor (1) and taps_in_use (2); it is
// always ready and should only be used while the block is idle.
// Sequence: a coefficient write is stored from the idle state. A sample is
// written into the delay line, then each output it causes passes through a
// residue check, a serial remainder for the phase row, the T taps (T =
// taps_in_use) through the single shared multiply-accumulate plus its pipeline
// drain, a rounding step and a hand-over.
// req_i is not ready while a sample is being worked on.
// Reset clears the delay line (through a fill count), the residue and sets all
// three registers to 1; the coefficient store is not cleared and must be
// written before use. A stalled receiver holds the output register; the block
// waits with the next result until that transfer completes, but takes a new
// request as soon as the last result of a sample sits in the output register.
module polyphase_rational_resampler import prr_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF,
  parameter int MAX_UP   = MAX_UP_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  prr_cfg_if.sink   cfg_i,
  prr_in_if.sink    req_i,
  prr_out_if.source res_o
);

  // Delay line holds MAX_TAPS samples plus one for the one-older window end.
  localparam int DEPTH = MAX_TAPS + 1;
  localparam int DAW   = $clog2(DEPTH);
  localparam int DAW1  = DAW + 1;
  localparam int FCW   = $clog2(DEPTH + 1);
  localparam int TCW   = $clog2(MAX_TAPS + 1);
  localparam int TXW   = (TCW > TAPS_W) ? TCW : TAPS_W;
  localparam int TAW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int LW    = $clog2(MAX_UP + 1);
  localparam int LXW   = (LW > UP_W) ? LW : UP_W;
  localparam int RAW   = (MAX_UP > 1) ? $clog2(MAX_UP) : 1;
  localparam int CAW   = RAW + TAW;
  localparam int CNTW  = $clog2(RESIDUE_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MAC,
    ST_ROUND,
    ST_EMIT
  } state_e;

  state_e                     state_q, state_d;
  logic [UP_W-1:0]            up_q, up_d;
  logic [DOWN_W-1:0]          down_q, down_d;
  logic [TAPS_W-1:0]          taps_q, taps_d;
  logic [DAW-1:0]             head_q, head_d;
  logic [FCW-1:0]             fill_q, fill_d;
  logic [RESIDUE_W-1:0]       residue_q, residue_d;
  logic [RESULT_CNT_W-1:0]    n_q, n_d;
  logic                       last_q, last_d;
  logic [RESIDUE_W-1:0]       dsh_q, dsh_d;
  logic [LW:0]                rem_q, rem_d;
  logic [CNTW-1:0]            cnt_q, cnt_d;
  logic [RAW-1:0]             p_q, p_d;
  logic                       end_q, end_d;
  logic [TCW-1:0]             k_q, k_d;
  logic                       rd_vld_q, rd_vld_d;
  logic                       rd_zero_q, rd_zero_d;
  logic signed [SAMPLE_W-1:0] res_q, res_d;
  logic                       out_vld_q, out_vld_d;
  logic signed [SAMPLE_W-1:0] out_data_q, out_data_d;
  logic                       out_last_q, out_last_d;

  // Effective (clamped) factors.
  logic [LW-1:0]              l_eff;
  logic [DOWN_W-1:0]          m_eff;
  logic [TCW-1:0]             t_eff;
  logic [LXW-1:0]             up_x;
  logic [TXW-1:0]             taps_x;

  // Datapath helpers.
  logic                       accept;
  logic [RESIDUE_W-1:0]       m_ext;
  logic [RESIDUE_W-1:0]       d_val;
  logic                       ge_m;
  logic                       more;
  logic [LW:0]                rem_sh;
  logic [LW:0]                rem_nx;
  logic                       issue;
  logic [DAW-1:0]             age;
  logic [DAW1-1:0]            wrap;
  logic [DAW-1:0]             head_nx;

  // Memory ports.
  logic                       coef_we;
  logic [CAW-1:0]             coef_waddr;
  logic [CAW-1:0]             coef_raddr;
  logic signed [COEF_W-1:0]   coef_mem [2**CAW];
  logic signed [COEF_W-1:0]   coef_rd_q;
  logic                       dly_we;
  logic [DAW-1:0]             dly_raddr;
  logic signed [SAMPLE_W-1:0] dly_mem [DEPTH];
  logic signed [SAMPLE_W-1:0] dly_rd_q;

  // Shared MAC.
  mac_ctrl_t                  mac_ctrl;
  logic                       mac_busy;
  logic signed [SAMPLE_W-1:0] mac_smp;
  logic signed [SAMPLE_W-1:0] mac_result;

  // Clamp L to 1..MAX_UP, M to at least 1, T to 1..MAX_TAPS.
  always_comb begin
    up_x = LXW'(up_q);
    if (up_x == '0) begin
      l_eff = LW'(1);
    end else if (up_x > LXW'(MAX_UP)) begin
      l_eff = LW'(MAX_UP);
    end else begin
      l_eff = LW'(up_x);
    end

    m_eff = (down_q == '0) ? DOWN_W'(1) : down_q;

    taps_x = TXW'(taps_q);
    if (taps_x == '0) begin
      t_eff = TCW'(1);
    end else if (taps_x > TXW'(MAX_TAPS)) begin
      t_eff = TCW'(MAX_TAPS);
    end else begin
      t_eff = TCW'(taps_x);
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = req_i.valid && req_i.ready;

  assign m_ext = RESIDUE_W'(m_eff);
  assign d_val = residue_q - m_ext;
  assign ge_m  = residue_q >= m_ext;
  // Another output follows this one if the residue stays at or above M and
  // the per-sample cap is not reached.
  assign more  = (d_val >= m_ext) && (n_q != RESULT_CNT_W'(RESULT_CAP - 1));

  // Serial remainder step: shift one residue bit in, subtract L if it fits.
  assign rem_sh = {rem_q[LW-1:0], dsh_q[RESIDUE_W-1]};
  assign rem_nx = (rem_sh >= (LW+1)'(l_eff)) ? rem_sh - (LW+1)'(l_eff) : rem_sh;

  // Tap k reads the sample (T - 1 - k) older than the window end.
  assign issue      = (state_q == ST_MAC) && (k_q != t_eff);
  assign age        = DAW'(t_eff) - DAW'(k_q) - DAW'(1) + DAW'(end_q);
  assign wrap       = DAW1'(head_q) + DAW1'(DEPTH) - DAW1'(age);
  assign dly_raddr  = (head_q >= age) ? head_q - age : wrap[DAW-1:0];
  assign coef_raddr = {p_q, TAW'(k_q)};
  assign head_nx    = (head_q == DAW'(DEPTH - 1)) ? '0 : head_q + DAW'(1);

  assign coef_waddr = {RAW'(req_i.coef_phase), TAW'(req_i.coef_tap)};

  always_comb begin
    state_d    = state_q;
    up_d       = up_q;
    down_d     = down_q;
    taps_d     = taps_q;
    head_d     = head_q;
    fill_d     = fill_q;
    residue_d  = residue_q;
    n_d        = n_q;
    last_d     = last_q;
    dsh_d      = dsh_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    p_d        = p_q;
    end_d      = end_q;
    k_d        = k_q;
    rd_vld_d   = 1'b0;
    rd_zero_d  = rd_zero_q;
    res_d      = res_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    coef_we    = 1'b0;
    dly_we     = 1'b0;
    mac_ctrl   = '{clr: 1'b0, vld: rd_vld_q};

    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_UP:   up_d   = cfg_i.data[UP_W-1:0];
        REG_DOWN: down_d = cfg_i.data[DOWN_W-1:0];
        REG_TAPS: taps_d = cfg_i.data[TAPS_W-1:0];
        default: ;
      endcase
    end

    // Drop the output once the receiver takes it.
    if (out_vld_q && res_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.req_type == REQ_COEF) begin
            coef_we = (int'(req_i.coef_phase) < MAX_UP) && (int'(req_i.coef_tap) < MAX_TAPS);
          end else begin
            dly_we    = 1'b1;
            head_d    = head_nx;
            fill_d    = (fill_q == FCW'(DEPTH)) ? fill_q : fill_q + FCW'(1);
            residue_d = residue_q + RESIDUE_W'(l_eff);
            n_d       = '0;
            state_d   = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (ge_m && (n_q != RESULT_CNT_W'(RESULT_CAP))) begin
          last_d  = !more;
          dsh_d   = d_val;
          rem_d   = '0;
          cnt_d   = '0;
          end_d   = (d_val != '0);
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        rem_d = rem_nx;
        dsh_d = dsh_q << 1;
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(RESIDUE_W - 1)) begin
          // Phase row is (-d) mod L.
          p_d          = (rem_nx == '0) ? '0 : RAW'((LW+1)'(l_eff) - rem_nx);
          k_d          = '0;
          mac_ctrl.clr = 1'b1;
          state_d      = ST_MAC;
        end
      end
      ST_MAC: begin
        if (issue) begin
          k_d       = k_q + TCW'(1);
          rd_vld_d  = 1'b1;
          rd_zero_d = FCW'(age) >= fill_q;
        end else if (!rd_vld_q && !mac_busy) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        res_d   = mac_result;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold the result until the output register is free.
        if (!out_vld_q || res_o.ready) begin
          out_vld_d  = 1'b1;
          out_data_d = res_q;
          out_last_d = last_q;
          residue_d  = residue_q - m_ext;
          n_d        = n_q + RESULT_CNT_W'(1);
          state_d    = last_q ? ST_IDLE : ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      up_q       <= UP_W'(1);
      down_q     <= DOWN_W'(1);
      taps_q     <= TAPS_W'(1);
      head_q     <= '0;
      fill_q     <= '0;
      residue_q  <= '0;
      n_q        <= '0;
      last_q     <= 1'b0;
      dsh_q      <= '0;
      rem_q      <= '0;
      cnt_q      <= '0;
      p_q        <= '0;
      end_q      <= 1'b0;
      k_q        <= '0;
      rd_vld_q   <= 1'b0;
      rd_zero_q  <= 1'b0;
      res_q      <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      up_q       <= up_d;
      down_q     <= down_d;
      taps_q     <= taps_d;
      head_q     <= head_d;
      fill_q     <= fill_d;
      residue_q  <= residue_d;
      n_q        <= n_d;
      last_q     <= last_d;
      dsh_q      <= dsh_d;
      rem_q      <= rem_d;
      cnt_q      <= cnt_d;
      p_q        <= p_d;
      end_q      <= end_d;
      k_q        <= k_d;
      rd_vld_q   <= rd_vld_d;
      rd_zero_q  <= rd_zero_d;
      res_q      <= res_d;
      out_vld_q  <= out_vld_d;
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  // Coefficient store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= req_i.coef_value;
    end
    coef_rd_q <= coef_mem[coef_raddr];
  end

  // Delay line: circular buffer, the newest sample sits at head.
  always_ff @(posedge clk_i) begin
    if (dly_we) begin
      dly_mem[head_nx] <= req_i.sample_in;
    end
    dly_rd_q <= dly_mem[dly_raddr];
  end

  // Entries never pushed since reset read as zero.
  assign mac_smp = rd_zero_q ? '0 : dly_rd_q;

  prr_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_rd_q),
    .smp_i    (mac_smp),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  assign res_o.valid      = out_vld_q;
  assign res_o.sample_out = out_data_q;
  assign res_o.last       = out_last_q;

  // A pending result never overwrites a stalled one.
  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_vld_q && !res_o.ready) |=> (state_q == ST_EMIT))
    else $error("result handed over while output register stalled");

  // The fill count saturates at the delay line depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FCW'(DEPTH))
    else $error("delay line fill count overran");

  // The phase row picked by the remainder unit stays below L.
  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (LW'(p_q) < l_eff))
    else $error("phase row out of range");

  // Reads only fly while the MAC sequence runs.
  a_read_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == ST_MAC))
    else $error("tap read issued outside MAC sequence");

  // No sample causes more than the capped number of outputs.
  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= RESULT_CNT_W'(RESULT_CAP))
    else $error("too many outputs for one sample");

endmodule
